@@ rtl/core/rmm_pkg.sv @@
// Package: shared types and constants for the rendezvous message matcher.
`default_nettype none
package rmm_pkg;

    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int MESSAGE_WIDTH_DEF = 32;
    localparam int ID_WIDTH_DEF      = 8;

    localparam int ID_FIELD_W  = 8;
    localparam int MSG_FIELD_W = 32;

    localparam logic [1:0] ST_PAIRED = 2'd0;
    localparam logic [1:0] ST_QUEUED = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic MODE_SEND = 1'b0;
    localparam logic MODE_RECV = 1'b1;

    typedef struct packed {
        logic                   mode;
        logic [ID_FIELD_W-1:0]  caller_id;
        logic [MSG_FIELD_W-1:0] message_in;
    } req_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [ID_FIELD_W-1:0]  wake_id;
        logic [ID_FIELD_W-1:0]  receiver_id;
        logic [ID_FIELD_W-1:0]  sender_id;
        logic [MSG_FIELD_W-1:0] message_out;
    } rsp_t;

endpackage
`default_nettype wire

@@ rtl/core/rmm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/rendezvous_message_matcher.sv @@
// Top level: rendezvous matcher with one waiter FIFO in RAM and a side flag.
// Queued or rejected requests are answered from S_DECIDE; paired requests read
// the waiting partner from the RAM in S_DECIDE and are answered from S_PAIR.
// The response is registered; answering waits while the output is stalled.
// One request register: s_ready stays low until the held request is answered.
// Reset (aresetn low, synchronous): FIFO empty, senders side, no result pending.
`default_nettype none
module rendezvous_message_matcher #(
    parameter int QUEUE_DEPTH   = rmm_pkg::QUEUE_DEPTH_DEF,
    parameter int MESSAGE_WIDTH = rmm_pkg::MESSAGE_WIDTH_DEF,
    parameter int ID_WIDTH      = rmm_pkg::ID_WIDTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire rmm_pkg::req_t s_req,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rmm_pkg::rsp_t      m_rsp
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = rmm_pkg::ID_FIELD_W;
    localparam int MW = rmm_pkg::MSG_FIELD_W;
    localparam int RW = ID_WIDTH + MESSAGE_WIDTH;

    localparam logic S_DECIDE = 1'b0;
    localparam logic S_PAIR   = 1'b1;

    rmm_pkg::req_t req_reg, req_next;
    logic          req_valid_reg, req_valid_next;
    logic          phase_reg, phase_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          side_reg, side_next;
    logic          m_valid_reg, m_valid_next;
    rmm_pkg::rsp_t rsp_reg, rsp_next;

    logic          out_free;
    logic          pair_hit;
    logic          full;
    logic          load;
    logic          wr_en;
    logic          rd_en;
    logic [RW-1:0] wr_data;
    logic [RW-1:0] rd_data;

    logic [ID_WIDTH+IW-1:0]      caller_ext;
    logic [ID_WIDTH-1:0]         caller_w;
    logic [MESSAGE_WIDTH+MW-1:0] msg_ext;
    logic [MESSAGE_WIDTH-1:0]    msg_w;
    logic [ID_WIDTH-1:0]         partner_w;
    logic [MESSAGE_WIDTH-1:0]    pmsg_w;
    logic [ID_WIDTH+IW-1:0]      caller_out_ext;
    logic [ID_WIDTH+IW-1:0]      partner_out_ext;
    logic [MESSAGE_WIDTH+MW-1:0] msg_out_ext;
    logic [MESSAGE_WIDTH+MW-1:0] pmsg_out_ext;
    logic [IW-1:0]               caller_o;
    logic [IW-1:0]               partner_o;
    logic [MW-1:0]               msg_o;
    logic [MW-1:0]               pmsg_o;

    rmm_ram #(
        .WIDTH(RW),
        .DEPTH(QUEUE_DEPTH)
    ) u_waiters (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(tail_reg),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(head_reg),
        .rd_data(rd_data)
    );

    assign caller_ext      = {{ID_WIDTH{1'b0}}, req_reg.caller_id};
    assign caller_w        = caller_ext[ID_WIDTH-1:0];
    assign msg_ext         = {{MESSAGE_WIDTH{1'b0}}, req_reg.message_in};
    assign msg_w           = (req_reg.mode == rmm_pkg::MODE_RECV) ?
                             '0 : msg_ext[MESSAGE_WIDTH-1:0];
    assign partner_w       = rd_data[RW-1:MESSAGE_WIDTH];
    assign pmsg_w          = rd_data[MESSAGE_WIDTH-1:0];
    assign caller_out_ext  = {{IW{1'b0}}, caller_w};
    assign partner_out_ext = {{IW{1'b0}}, partner_w};
    assign msg_out_ext     = {{MW{1'b0}}, msg_w};
    assign pmsg_out_ext    = {{MW{1'b0}}, pmsg_w};
    assign caller_o        = caller_out_ext[IW-1:0];
    assign partner_o       = partner_out_ext[IW-1:0];
    assign msg_o           = msg_out_ext[MW-1:0];
    assign pmsg_o          = pmsg_out_ext[MW-1:0];
    assign wr_data         = {caller_w, msg_w};

    assign out_free = !m_valid_reg || m_ready;
    assign pair_hit = (count_reg != '0) && (side_reg != req_reg.mode);
    assign full     = (count_reg == CW'(QUEUE_DEPTH));

    assign s_ready = !req_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

    always_comb begin
        req_next       = req_reg;
        req_valid_next = req_valid_reg;
        phase_next     = phase_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        side_next      = side_reg;
        m_valid_next   = m_valid_reg;
        rsp_next       = rsp_reg;
        load           = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (req_valid_reg) begin
            case (phase_reg)
                S_DECIDE: begin
                    if (pair_hit) begin
                        rd_en      = 1'b1;
                        head_next  = (head_reg == AW'(QUEUE_DEPTH - 1)) ?
                                     '0 : head_reg + AW'(1);
                        count_next = count_reg - CW'(1);
                        phase_next = S_PAIR;
                    end else if (out_free) begin
                        load           = 1'b1;
                        req_valid_next = 1'b0;
                        rsp_next       = '0;
                        if (full) begin
                            rsp_next.status = rmm_pkg::ST_FULL;
                        end else begin
                            wr_en           = 1'b1;
                            tail_next       = (tail_reg == AW'(QUEUE_DEPTH - 1)) ?
                                              '0 : tail_reg + AW'(1);
                            count_next      = count_reg + CW'(1);
                            side_next       = req_reg.mode;
                            rsp_next.status = rmm_pkg::ST_QUEUED;
                        end
                    end
                end
                S_PAIR: begin
                    if (out_free) begin
                        load                 = 1'b1;
                        req_valid_next       = 1'b0;
                        phase_next           = S_DECIDE;
                        rsp_next.status      = rmm_pkg::ST_PAIRED;
                        rsp_next.wake_id     = partner_o;
                        if (req_reg.mode == rmm_pkg::MODE_SEND) begin
                            rsp_next.receiver_id = partner_o;
                            rsp_next.sender_id   = caller_o;
                            rsp_next.message_out = msg_o;
                        end else begin
                            rsp_next.receiver_id = caller_o;
                            rsp_next.sender_id   = partner_o;
                            rsp_next.message_out = pmsg_o;
                        end
                    end
                end
                default: begin
                    phase_next = S_DECIDE;
                end
            endcase
        end

        if (load) begin
            m_valid_next = 1'b1;
        end

        if (!req_valid_reg && s_valid) begin
            req_valid_next = 1'b1;
            req_next       = s_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            phase_reg     <= S_DECIDE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            side_reg      <= rmm_pkg::MODE_SEND;
            m_valid_reg   <= 1'b0;
        end else begin
            req_valid_reg <= req_valid_next;
            phase_reg     <= phase_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            side_reg      <= side_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("waiter count exceeds queue depth");

    a_pair_needs_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == S_PAIR) |-> req_valid_reg)
        else $error("pair phase without a held request");

    a_read_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (count_reg != '0) && !wr_en)
        else $error("pop from empty queue or overlapping access");

    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && rsp_next.status == rmm_pkg::ST_FULL) |-> full)
        else $error("request rejected while queue has room");

    a_pair_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |=> (phase_reg == S_PAIR))
        else $error("RAM read not followed by pair phase");

endmodule
`default_nettype wire
